@@ hdl/crc16frx_pkg.sv @@
// ----------------------------------------------------------------------------
// crc16frx_pkg
// Shared types, codes and the byte-wide crc step for the frame receiver.
// ----------------------------------------------------------------------------
package crc16frx_pkg;

    // frame layout
    localparam int HEADER_BYTES = 4;
    localparam int CRC_BYTES    = 2;

    // byte kind codes
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_CRC     = 2'd2;

    // configuration register indexes
    localparam logic REG_CRC_POLYNOMIAL = 1'b0;
    localparam logic REG_PAYLOAD_LENGTH = 1'b1;

    // register reset values
    localparam logic [15:0] POLY_RESET   = 16'h1021;
    localparam logic [8:0]  LENGTH_RESET = 9'd32;

    // one result item
    typedef struct packed {
        logic [1:0]  byte_kind;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic        frame_end;
        logic        crc_ok;
        logic        header_ok;
        logic [1:0]  frame_opcode;
        logic [1:0]  length_code;
        logic        ack_flag;
        logic [10:0] pkt_number;
        logic [15:0] received_crc;
    } frx_result_t;

    // msb-first crc-16 over one byte, eight shift steps
    function automatic logic [15:0] crc_byte_step(
        input logic [15:0] crc,
        input logic [7:0]  data,
        input logic [15:0] poly
    );
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ poly;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

@@ hdl/crc16_packet_frame_receiver_top.sv @@
// ----------------------------------------------------------------------------
// crc16_packet_frame_receiver_top
// Receives framed bytes, checks the crc-16 and header, streams the payload.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  input     in         in_valid / in_stall    rx_byte
//  output    out        out_valid / out_stall  byte_kind .. received_crc
//  config    in/out     apb psel/penable       paddr, pwdata, prdata
//
//  one byte is taken per cycle while in_stall is low; its result is registered
//  into a two-entry output buffer (result register plus skid) that decouples
//  the sides, so in_stall rises only when both entries hold results
//  the byte-wide crc update and the position compare set the cycle path
//  reset returns the frame position, crc and registers to their reset values
// ----------------------------------------------------------------------------
module crc16_packet_frame_receiver_top #(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  byte_kind,
    output logic [7:0]  payload_byte,
    output logic [7:0]  payload_index,
    output logic        frame_end,
    output logic        crc_ok,
    output logic        header_ok,
    output logic [1:0]  frame_opcode,
    output logic [1:0]  length_code,
    output logic        ack_flag,
    output logic [10:0] pkt_number,
    output logic [15:0] received_crc,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] poly_reg;
    logic [8:0]  len_reg;
    logic        reg_index;
    logic        cfg_write;

    crc16frx_pkg::frx_result_t core_result;
    crc16frx_pkg::frx_result_t head_reg, head_next;
    crc16frx_pkg::frx_result_t skid_reg, skid_next;
    logic head_valid_reg, head_valid_next;
    logic skid_valid_reg, skid_valid_next;
    logic push, pop;

    // configuration registers
    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg <= crc16frx_pkg::POLY_RESET;
            len_reg  <= crc16frx_pkg::LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                crc16frx_pkg::REG_CRC_POLYNOMIAL: poly_reg <= pwdata[15:0];
                crc16frx_pkg::REG_PAYLOAD_LENGTH: len_reg  <= pwdata[8:0];
                default:                          ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        unique case (reg_index)
            crc16frx_pkg::REG_CRC_POLYNOMIAL: prdata = {16'h0000, poly_reg};
            crc16frx_pkg::REG_PAYLOAD_LENGTH: prdata = {23'h0, len_reg};
            default:                          prdata = 32'h0;
        endcase
    end

    // per-byte frame logic
    assign in_stall = skid_valid_reg;
    assign push     = in_valid && !in_stall;
    assign pop      = head_valid_reg && !out_stall;

    crc16frx_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (push),
        .rx_byte        (rx_byte),
        .crc_polynomial (poly_reg),
        .payload_length (len_reg),
        .result         (core_result)
    );

    // output buffer: head entry drives the port, skid takes overflow
    always_comb
    begin
        head_next       = head_reg;
        skid_next       = skid_reg;
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                head_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
                head_next = core_result;
            else
                head_valid_next = 1'b0;
        end
        else if (push)
        begin
            if (head_valid_reg)
            begin
                skid_next       = core_result;
                skid_valid_next = 1'b1;
            end
            else
            begin
                head_next       = core_result;
                head_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    // result ports
    assign out_valid     = head_valid_reg;
    assign byte_kind     = head_reg.byte_kind;
    assign payload_byte  = head_reg.payload_byte;
    assign payload_index = head_reg.payload_index;
    assign frame_end     = head_reg.frame_end;
    assign crc_ok        = head_reg.crc_ok;
    assign header_ok     = head_reg.header_ok;
    assign frame_opcode  = head_reg.frame_opcode;
    assign length_code   = head_reg.length_code;
    assign ack_flag      = head_reg.ack_flag;
    assign pkt_number    = head_reg.pkt_number;
    assign received_crc  = head_reg.received_crc;

endmodule

@@ hdl/crc16frx_core.sv @@
// ----------------------------------------------------------------------------
// crc16frx_core
// Frame position tracking, crc accumulation and header unpacking per byte.
// ----------------------------------------------------------------------------
module crc16frx_core #(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [7:0]                 rx_byte,
    input  logic [15:0]                crc_polynomial,
    input  logic [8:0]                 payload_length,
    output crc16frx_pkg::frx_result_t  result
);

    localparam int POS_W =
        $clog2(crc16frx_pkg::HEADER_BYTES + MAX_PAYLOAD + crc16frx_pkg::CRC_BYTES);
    localparam logic [8:0] MAX_LEN = 9'(MAX_PAYLOAD);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      crc_reg, crc_next;
    logic [31:0]      header_reg, header_next;
    logic [7:0]       crc_high_reg, crc_high_next;

    logic [8:0]       eff_len;
    logic [POS_W-1:0] crc_start;
    logic [15:0]      crc_upd;
    logic [15:0]      idx_wide;

    // clamp the payload length into range
    always_comb
    begin
        if (payload_length == 9'd0)
            eff_len = 9'd1;
        else if (payload_length > MAX_LEN)
            eff_len = MAX_LEN;
        else
            eff_len = payload_length;
    end

    assign crc_start = POS_W'(crc16frx_pkg::HEADER_BYTES) + POS_W'(eff_len);
    assign crc_upd   = crc16frx_pkg::crc_byte_step(crc_reg, rx_byte, crc_polynomial);
    assign idx_wide  = 16'(pos_reg) - 16'(crc16frx_pkg::HEADER_BYTES);

    // byte classification, next state and result
    always_comb
    begin
        pos_next      = pos_reg + POS_W'(1);
        crc_next      = crc_upd;
        header_next   = header_reg;
        crc_high_next = crc_high_reg;
        result        = '0;
        if (pos_reg < POS_W'(crc16frx_pkg::HEADER_BYTES))
        begin
            header_next      = {header_reg[23:0], rx_byte};
            result.byte_kind = crc16frx_pkg::KIND_HEADER;
        end
        else if (pos_reg < crc_start)
        begin
            result.byte_kind     = crc16frx_pkg::KIND_PAYLOAD;
            result.payload_byte  = rx_byte;
            result.payload_index = idx_wide[7:0];
        end
        else if (pos_reg == crc_start)
        begin
            result.byte_kind = crc16frx_pkg::KIND_CRC;
            crc_high_next    = rx_byte;
        end
        else
        begin
            // final crc byte: report header and status, restart the frame
            result.byte_kind     = crc16frx_pkg::KIND_CRC;
            result.frame_end     = 1'b1;
            result.crc_ok        = (crc_upd == 16'h0000);
            result.header_ok     = (~header_reg[31:16] == header_reg[15:0]);
            result.frame_opcode  = header_reg[31:30];
            result.length_code   = header_reg[29:28];
            result.ack_flag      = header_reg[27];
            result.pkt_number    = header_reg[26:16];
            result.received_crc  = {crc_high_reg, rx_byte};
            pos_next             = '0;
            crc_next             = 16'h0000;
        end
    end

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            crc_reg      <= 16'h0000;
            header_reg   <= 32'h0;
            crc_high_reg <= 8'h00;
        end
        else if (accept)
        begin
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            header_reg   <= header_next;
            crc_high_reg <= crc_high_next;
        end
    end

endmodule

@@ sim/crc16_packet_frame_receiver_top_tb.sv @@
// ----------------------------------------------------------------------------
// crc16_packet_frame_receiver_top_tb
// Streams framed bytes into the receiver under several crc polynomials and
// payload lengths. A byte-level model of the frame position, crc remainder and
// header predicts every result. Results are compared field by field in order.
// ----------------------------------------------------------------------------
module crc16_packet_frame_receiver_top_tb;

    localparam int QUIET_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int SMALL_PHASE   = 120;
    localparam int PHASE_COUNT   = 13;
    localparam int LENGTH_MAX    = 256;

    // dut signals
    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  byte_kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic        frame_end;
    logic        crc_ok;
    logic        header_ok;
    logic [1:0]  frame_opcode;
    logic [1:0]  length_code;
    logic        ack_flag;
    logic [10:0] pkt_number;
    logic [15:0] received_crc;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // run control
    int errors        = 0;
    int bytes_sent    = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int quiet_cycles  = 0;

    // byte-level model of the receiver and the results it still owes
    class frame_result_tracker;
        logic [15:0] poly;
        logic [8:0]  length_reg;
        logic [8:0]  position;
        logic [15:0] remainder;
        logic [31:0] header;
        logic [7:0]  crc_high;
        crc16frx_pkg::frx_result_t predicted_results[$];

        function new();
            poly       = crc16frx_pkg::POLY_RESET;
            length_reg = crc16frx_pkg::LENGTH_RESET;
            position   = '0;
            remainder  = '0;
            header     = '0;
            crc_high   = '0;
        endfunction

        // msb-first crc-16 advance by one byte
        static function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b,
                                              logic [15:0] p);
            logic [15:0] r;
            r = c ^ {b, 8'h00};
            for (int i = 0; i < 8; i++)
            begin
                if (r[15])
                    r = {r[14:0], 1'b0} ^ p;
                else
                    r = {r[14:0], 1'b0};
            end
            return r;
        endfunction

        // payload length clamped into the legal range
        function int frame_length();
            int len;
            len = int'(length_reg);
            if (len < 1)
                len = 1;
            if (len > LENGTH_MAX)
                len = LENGTH_MAX;
            return len;
        endfunction

        function void write_register(logic idx, logic [31:0] value);
            if (idx == crc16frx_pkg::REG_CRC_POLYNOMIAL)
                poly = value[15:0];
            else if (idx == crc16frx_pkg::REG_PAYLOAD_LENGTH)
                length_reg = value[8:0];
        endfunction

        // advance on one accepted byte and queue the result it causes
        function void take_byte(logic [7:0] b);
            int                        crc_start;
            crc16frx_pkg::frx_result_t r;
            logic [15:0]               pack;
            crc_start = crc16frx_pkg::HEADER_BYTES + frame_length();
            r = '0;
            remainder = crc_next(remainder, b, poly);
            if (position < crc16frx_pkg::HEADER_BYTES)
            begin
                header = {header[23:0], b};
                r.byte_kind = crc16frx_pkg::KIND_HEADER;
                position = position + 9'd1;
            end
            else if (position < crc_start)
            begin
                r.byte_kind     = crc16frx_pkg::KIND_PAYLOAD;
                r.payload_byte  = b;
                r.payload_index = 8'(position - crc16frx_pkg::HEADER_BYTES);
                position = position + 9'd1;
            end
            else if (position == crc_start)
            begin
                r.byte_kind = crc16frx_pkg::KIND_CRC;
                crc_high = b;
                position = position + 9'd1;
            end
            else
            begin
                // any crc byte past the first ends the frame
                r.byte_kind     = crc16frx_pkg::KIND_CRC;
                r.frame_end     = 1'b1;
                r.crc_ok        = (remainder == 16'h0000);
                r.frame_opcode  = header[31:30];
                r.length_code   = header[29:28];
                r.ack_flag      = header[27];
                r.pkt_number    = header[26:16];
                pack            = {header[31:30], header[29:28], header[27], header[26:16]};
                r.header_ok     = (~pack == header[15:0]);
                r.received_crc  = {crc_high, b};
                position  = '0;
                remainder = '0;
            end
            predicted_results.push_back(r);
        endfunction

        // compare one result with the oldest prediction
        function bit match_result(crc16frx_pkg::frx_result_t got, output string diff);
            crc16frx_pkg::frx_result_t want;
            diff = "";
            if (predicted_results.size() == 0)
            begin
                diff = "result with no byte waiting";
                return 1'b0;
            end
            want = predicted_results.pop_front();
            if (got.byte_kind !== want.byte_kind)
                diff = {diff, $sformatf(" byte_kind %0d/%0d", got.byte_kind, want.byte_kind)};
            if (got.payload_byte !== want.payload_byte)
                diff = {diff, $sformatf(" payload_byte %0h/%0h",
                                        got.payload_byte, want.payload_byte)};
            if (got.payload_index !== want.payload_index)
                diff = {diff, $sformatf(" payload_index %0d/%0d",
                                        got.payload_index, want.payload_index)};
            if (got.frame_end !== want.frame_end)
                diff = {diff, $sformatf(" frame_end %0b/%0b", got.frame_end, want.frame_end)};
            if (got.crc_ok !== want.crc_ok)
                diff = {diff, $sformatf(" crc_ok %0b/%0b", got.crc_ok, want.crc_ok)};
            if (got.header_ok !== want.header_ok)
                diff = {diff, $sformatf(" header_ok %0b/%0b", got.header_ok, want.header_ok)};
            if (got.frame_opcode !== want.frame_opcode)
                diff = {diff, $sformatf(" frame_opcode %0d/%0d",
                                        got.frame_opcode, want.frame_opcode)};
            if (got.length_code !== want.length_code)
                diff = {diff, $sformatf(" length_code %0d/%0d",
                                        got.length_code, want.length_code)};
            if (got.ack_flag !== want.ack_flag)
                diff = {diff, $sformatf(" ack_flag %0b/%0b", got.ack_flag, want.ack_flag)};
            if (got.pkt_number !== want.pkt_number)
                diff = {diff, $sformatf(" pkt_number %0h/%0h",
                                        got.pkt_number, want.pkt_number)};
            if (got.received_crc !== want.received_crc)
                diff = {diff, $sformatf(" received_crc %0h/%0h",
                                        got.received_crc, want.received_crc)};
            return (diff == "");
        endfunction

        function int pending();
            return predicted_results.size();
        endfunction
    endclass

    frame_result_tracker tracker = new();

    // dut
    crc16_packet_frame_receiver_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .byte_kind     (byte_kind),
        .payload_byte  (payload_byte),
        .payload_index (payload_index),
        .frame_end     (frame_end),
        .crc_ok        (crc_ok),
        .header_ok     (header_ok),
        .frame_opcode  (frame_opcode),
        .length_code   (length_code),
        .ack_flag      (ack_flag),
        .pkt_number    (pkt_number),
        .received_crc  (received_crc),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // clock
    always #1 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("mismatch at byte %0d: %s", bytes_sent, msg);
        errors++;
    endtask

    // output side: random stall, result check and quiet-cycle watchdog
    always @(posedge clk)
    begin
        crc16frx_pkg::frx_result_t got;
        string                     diff;
        out_stall <= ($urandom_range(99) < stall_pct);
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = {byte_kind, payload_byte, payload_index, frame_end, crc_ok, header_ok,
                       frame_opcode, length_code, ack_flag, pkt_number, received_crc};
                if (!tracker.match_result(got, diff))
                    report_mismatch(diff);
            end
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[crc16_packet_frame_receiver_top] ERROR");
                $finish;
            end
        end
    end

    // one byte transfer on the input channel, with an optional idle gap first
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            rx_byte  <= 8'($urandom);
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        rx_byte  <= b;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.take_byte(b);
        bytes_sent++;
    endtask

    // whole frame: header, payload and crc under the current settings
    task automatic send_frame(input logic [1:0] op, input logic [1:0] lc, input logic ack,
                              input logic [10:0] pn, input bit hdr_good, input bit crc_good,
                              input int fill);
        logic [7:0]  frame_bytes[$];
        logic [15:0] pack;
        logic [15:0] chk;
        logic [15:0] crc;
        int          len;
        len  = tracker.frame_length();
        pack = {op, lc, ack, pn};
        chk  = ~pack;
        if (!hdr_good)
            chk = chk ^ 16'($urandom_range(1, 65535));
        frame_bytes.push_back({op, lc, ack, pn[10:8]});
        frame_bytes.push_back(pn[7:0]);
        frame_bytes.push_back(chk[15:8]);
        frame_bytes.push_back(chk[7:0]);
        for (int i = 0; i < len; i++)
            frame_bytes.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
        crc = 16'h0000;
        foreach (frame_bytes[i])
            crc = frame_result_tracker::crc_next(crc, frame_bytes[i], tracker.poly);
        if (!crc_good)
            crc = crc ^ 16'($urandom_range(1, 65535));
        frame_bytes.push_back(crc[15:8]);
        frame_bytes.push_back(crc[7:0]);
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i]);
    endtask

    // stop sending and wait for every owed result
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    // register write followed by a read-back
    task automatic apb_write(input logic idx, input logic [31:0] value);
        logic [31:0] readback;
        logic [31:0] stored;
        stored = (idx == crc16frx_pkg::REG_CRC_POLYNOMIAL) ? {16'h0, value[15:0]}
                                                           : {23'h0, value[8:0]};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        tracker.write_register(idx, value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (readback !== stored)
            report_mismatch($sformatf("register %0d reads %0h, wrote %0h", idx, readback, stored));
    endtask

    // stimulus
    initial
    begin
        int          start;
        int          target;
        int          n;
        logic [15:0] poly_sel;
        logic [31:0] length_sel;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        rx_byte  = 8'h00;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        out_stall = 1'b0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: shortest frame, all-zero and all-one fields, bad header and crc
        apb_write(crc16frx_pkg::REG_PAYLOAD_LENGTH, 32'd1);
        send_frame(2'd0, 2'd0, 1'b0, 11'h000, 1'b1, 1'b1, 8'h00);
        send_frame(2'd3, 2'd3, 1'b1, 11'h7ff, 1'b1, 1'b1, 8'hff);
        send_frame(2'd2, 2'd1, 1'b0, 11'h555, 1'b0, 1'b0, -1);
        wait_drained();

        // random phases over polynomials, lengths and idle patterns
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            poly_sel   = 16'($urandom);
            length_sel = 32'($urandom_range(1, 20));
            case (phase)
                0:
                begin
                    poly_sel   = crc16frx_pkg::POLY_RESET;
                    length_sel = 32'd8;
                end
                1:
                begin
                    poly_sel   = 16'h8005;
                    length_sel = 32'd3;
                end
                2:
                begin
                    poly_sel   = 16'h0000;
                    length_sel = 32'd0;
                end
                3:
                begin
                    poly_sel   = 16'hffff;
                    length_sel = 32'd16;
                end
                4: length_sel = 32'd256;
                5: length_sel = 32'd1;
                6:
                begin
                    poly_sel   = 16'hc867;
                    length_sel = 32'($urandom_range(1, 12));
                end
                7: length_sel = 32'd511;
                8: length_sel = 32'd2;
                default: ;
            endcase
            // upper data bits are random and must be dropped by the registers
            apb_write(crc16frx_pkg::REG_CRC_POLYNOMIAL, {16'($urandom), poly_sel});
            apb_write(crc16frx_pkg::REG_PAYLOAD_LENGTH, {23'($urandom), length_sel[8:0]});
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 45;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 45;
                end
                default:
                begin
                    send_idle_pct = 34;
                    stall_pct     = 34;
                end
            endcase

            // finish a frame left open by the last phase under the new length
            while (tracker.position != 0)
                send_byte(8'($urandom));

            target = (tracker.frame_length() > 64) ? 1 : SMALL_PHASE;
            start  = bytes_sent;
            while (bytes_sent - start < target)
                send_frame(2'($urandom), 2'($urandom), 1'($urandom), 11'($urandom),
                           ($urandom_range(9) < 8), ($urandom_range(9) < 8), -1);

            // sometimes leave a frame open across the next register write
            if ($urandom_range(1) == 0)
            begin
                n = $urandom_range(1, crc16frx_pkg::HEADER_BYTES + tracker.frame_length() + 1);
                repeat (n)
                    send_byte(8'($urandom));
            end
            wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (tracker.pending() != 0)
            report_mismatch($sformatf("%0d results never arrived", tracker.pending()));
        if (errors == 0)
            $display("[crc16_packet_frame_receiver_top] OK");
        else
            $display("[crc16_packet_frame_receiver_top] ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/crc16frx_pkg.sv
hdl/crc16frx_core.sv
hdl/crc16_packet_frame_receiver_top.sv
sim/crc16_packet_frame_receiver_top_tb.sv
